FILE: sv/packed_pixel_line_mirror_top_macros.svh
// assertion macros for the line mirror block
`ifndef PACKED_PIXEL_LINE_MIRROR_TOP_MACROS_SVH
`define PACKED_PIXEL_LINE_MIRROR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PPLM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line mirror check failed");
`define PPLM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line mirror check failed");
`else
`define PPLM_ASSERT_NOW(name, ante, cons)
`define PPLM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: sv/pplm_pkg.sv
// shared types and constants for the line mirror block
package pplm_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int IDX_W          = $clog2(MAX_LINE_BYTES);
  localparam int POS_W          = IDX_W + 1;
  localparam int ADDR_W         = IDX_W + 1;
  localparam int SIDX_W         = 19;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_WIDTH  = 2'd1;

  typedef enum logic [2:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_16BPP = 3'd3,
    FMT_24BPP = 3'd4,
    FMT_32BPP = 3'd5
  } fmt_t;

  typedef logic signed [SIDX_W-1:0] sidx_t;

  typedef struct packed {
    fmt_t       fmt;
    logic [2:0] off;
    logic       ok0;
    logic       ok1;
  } src_sel_t;

  typedef struct packed {
    logic     emit;
    logic     last;
    src_sel_t sel;
  } s1_t;

endpackage

FILE: sv/pplm_ram.sv
// line store: one write port, two registered read ports
module pplm_ram #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: sv/pplm_src_addr.sv
// source byte addresses for one mirrored output byte
module pplm_src_addr (
  input  pplm_pkg::fmt_t                 fmt,
  input  pplm_pkg::sidx_t                width_m1,
  input  pplm_pkg::sidx_t                fmt_base,
  input  logic [pplm_pkg::IDX_W-1:0]     rpos,
  input  logic [1:0]                     rmod3,
  input  logic [pplm_pkg::POS_W-1:0]     row_len,
  input  logic                           emit,
  output logic [pplm_pkg::IDX_W-1:0]     idx0,
  output logic [pplm_pkg::IDX_W-1:0]     idx1,
  output pplm_pkg::src_sel_t             sel
);
  import pplm_pkg::*;

  sidx_t      j_ext;
  sidx_t      xt_bit;
  sidx_t      xt_nib;
  sidx_t      hi;
  sidx_t      lo;
  sidx_t      len_ext;
  logic [1:0] rem;
  logic       known;

  always_comb begin
    j_ext   = $signed({{(SIDX_W-IDX_W){1'b0}}, rpos});
    len_ext = $signed({{(SIDX_W-POS_W){1'b0}}, row_len});
    // top pixel index of this byte, counted from the row start
    xt_bit  = width_m1 - (j_ext <<< 3);
    xt_nib  = width_m1 - (j_ext <<< 1);
    rem     = 2'd0;
    known   = 1'b1;
    sel.off = 3'd0;
    case (fmt)
      FMT_16BPP: rem = {1'b0, rpos[0]};
      FMT_24BPP: rem = rmod3;
      FMT_32BPP: rem = rpos[1:0];
      default:   rem = 2'd0;
    endcase
    case (fmt)
      FMT_1BPP: begin
        hi      = xt_bit >>> 3;
        sel.off = xt_bit[2:0];
      end
      FMT_4BPP: begin
        hi      = xt_nib >>> 1;
        sel.off = {2'b00, xt_nib[0]};
      end
      FMT_8BPP, FMT_16BPP, FMT_24BPP, FMT_32BPP: begin
        // (w-1-j/n)*n + j%n rewritten as n*w - n - j + 2*(j%n)
        hi = fmt_base - j_ext + $signed({{(SIDX_W-3){1'b0}}, rem, 1'b0});
      end
      default: begin
        hi    = '0;
        known = 1'b0;
      end
    endcase
    lo      = hi - sidx_t'(1);
    sel.fmt = fmt;
    sel.ok1 = emit && known && !hi[SIDX_W-1] && (hi < len_ext);
    sel.ok0 = emit && known && !lo[SIDX_W-1] && (lo < len_ext);
    idx1    = hi[IDX_W-1:0];
    idx0    = lo[IDX_W-1:0];
  end

endmodule

FILE: sv/pplm_unpack.sv
// builds the mirrored byte from the two source bytes
module pplm_unpack (
  input  pplm_pkg::s1_t s1,
  input  logic [7:0]    rdata0,
  input  logic [7:0]    rdata1,
  output logic [7:0]    mirrored
);
  import pplm_pkg::*;

  logic [15:0] pair;
  logic [15:0] shifted;
  logic [7:0]  win;

  always_comb begin
    // out-of-row source bytes read as zero, which also masks missing pixels
    pair    = {s1.sel.ok0 ? rdata0 : 8'h00, s1.sel.ok1 ? rdata1 : 8'h00};
    shifted = pair << ({1'b0, s1.sel.off} + 4'd1);
    win     = shifted[15:8];
    case (s1.sel.fmt)
      FMT_1BPP: begin
        for (int i = 0; i < 8; i++) begin
          mirrored[i] = win[7-i];
        end
      end
      FMT_4BPP: begin
        mirrored = s1.sel.off[0] ? {pair[3:0], pair[7:4]} : {pair[7:4], pair[11:8]};
      end
      FMT_8BPP, FMT_16BPP, FMT_24BPP, FMT_32BPP: begin
        mirrored = pair[7:0];
      end
      default: begin
        mirrored = 8'h00;
      end
    endcase
    if (!s1.emit) begin
      mirrored = 8'h00;
    end
  end

endmodule

FILE: sv/packed_pixel_line_mirror_top.sv
// line mirror top level: control, ping-pong line store and output stage
//
//  channel   valid/ready          payload
//  cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//  in        in_valid/in_ready    data_byte, end_of_row, drain
//  result    res_valid/res_ready  out_byte, out_valid, out_last
//
// one item per cycle while results are taken; each result is offered after its transfer
// passes the line store read at the transfer edge and then the output register, both source
// bytes of an output byte coming from the two store read ports in that one read.
// reset clears control state only; the line store is never cleared.
// a stalled result holds the read stage, and input is refused only when both are full.
`include "packed_pixel_line_mirror_top_macros.svh"
module packed_pixel_line_mirror_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pplm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pplm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_row,
  input  logic                            drain,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_valid,
  output logic                            out_last
);
  import pplm_pkg::*;

  fmt_t             pixel_format;
  logic [15:0]      pixel_width;
  sidx_t            width_m1;
  sidx_t            fmt_base;
  logic             write_bank;
  logic [POS_W-1:0] write_position;
  logic [POS_W-1:0] read_position;
  logic [1:0]       read_mod3;
  logic [POS_W-1:0] stored_row_length;
  logic             row_ready;
  logic             s1_valid;
  s1_t              s1;

  fmt_t             fmt_next;
  logic [15:0]      width_next;
  sidx_t            wide_next;
  sidx_t            fmt_base_next;
  logic             cfg_write;
  logic             accept;
  logic             advance;
  logic             emit;
  logic             last;
  logic             room;
  logic [POS_W-1:0] write_position_next;
  logic             mem_we;
  logic [IDX_W-1:0] idx0;
  logic [IDX_W-1:0] idx1;
  src_sel_t         sel;
  logic [7:0]       rdata0;
  logic [7:0]       rdata1;
  logic [7:0]       mirrored;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // per-format constant n*w - n (zero for the other formats), kept up to date on every register write
  always_comb begin
    fmt_next   = (cfg_write && cfg_index == CFG_PIXEL_FORMAT) ?
                 fmt_t'(cfg_data[2:0]) : pixel_format;
    width_next = (cfg_write && cfg_index == CFG_PIXEL_WIDTH) ? cfg_data : pixel_width;
    wide_next  = $signed({{(SIDX_W-16){1'b0}}, width_next});
    case (fmt_next)
      FMT_8BPP:  fmt_base_next = wide_next - sidx_t'(1);
      FMT_16BPP: fmt_base_next = (wide_next <<< 1) - sidx_t'(2);
      FMT_24BPP: fmt_base_next = wide_next + (wide_next <<< 1) - sidx_t'(3);
      FMT_32BPP: fmt_base_next = (wide_next <<< 2) - sidx_t'(4);
      default:   fmt_base_next = '0;
    endcase
  end

  assign advance  = s1_valid && (!res_valid || res_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  assign emit = row_ready && (read_position < stored_row_length);
  assign last = emit && (read_position + POS_W'(1) == stored_row_length);
  assign room = write_position < POS_W'(MAX_LINE_BYTES);
  assign write_position_next = room ? write_position + POS_W'(1) : write_position;
  assign mem_we = accept && !drain && room;

  pplm_src_addr u_addr (
    .fmt      (pixel_format),
    .width_m1 (width_m1),
    .fmt_base (fmt_base),
    .rpos     (read_position[IDX_W-1:0]),
    .rmod3    (read_mod3),
    .row_len  (stored_row_length),
    .emit     (emit),
    .idx0     (idx0),
    .idx1     (idx1),
    .sel      (sel)
  );

  // reads hit the bank not being written, so no same-entry overlap in a cycle;
  // a bank written just before a swap is read by the next transfer after it at the earliest
  pplm_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  ({write_bank, write_position[IDX_W-1:0]}),
    .wdata  (data_byte),
    .re     (accept),
    .raddr0 ({!write_bank, idx0}),
    .raddr1 ({!write_bank, idx1}),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  pplm_unpack u_unpack (
    .s1       (s1),
    .rdata0   (rdata0),
    .rdata1   (rdata1),
    .mirrored (mirrored)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format      <= FMT_8BPP;
      pixel_width       <= 16'd1;
      width_m1          <= '0;
      fmt_base          <= '0;
      write_bank        <= 1'b0;
      write_position    <= '0;
      read_position     <= '0;
      read_mod3         <= 2'd0;
      stored_row_length <= '0;
      row_ready         <= 1'b0;
      s1_valid          <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        pixel_format <= fmt_next;
        pixel_width  <= width_next;
        width_m1     <= wide_next - sidx_t'(1);
        fmt_base     <= fmt_base_next;
      end

      if (accept) begin
        s1_valid <= 1'b1;
        if (emit) begin
          read_position <= read_position + POS_W'(1);
          read_mod3     <= (read_mod3 == 2'd2) ? 2'd0 : read_mod3 + 2'd1;
          if (last) begin
            row_ready <= 1'b0;
          end
        end
        if (!drain) begin
          write_position <= write_position_next;
          if (end_of_row) begin
            // row complete: swap banks, abandon whatever is left of the old row
            stored_row_length <= write_position_next;
            write_bank        <= !write_bank;
            write_position    <= '0;
            read_position     <= '0;
            read_mod3         <= 2'd0;
            row_ready         <= (write_position_next != '0);
          end
        end
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.emit <= emit;
      s1.last <= last;
      s1.sel  <= sel;
    end
    if (advance) begin
      out_byte  <= mirrored;
      out_valid <= s1.emit;
      out_last  <= s1.last;
    end
  end

  `PPLM_ASSERT_NOW(a_row_in_range, row_ready, read_position < stored_row_length)
  `PPLM_ASSERT_NEXT(a_last_ends_row, accept && last && (drain || !end_of_row), !row_ready)
  `PPLM_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid)
  `PPLM_ASSERT_NOW(a_empty_result, res_valid && !out_valid, out_byte == 8'h00 && !out_last)

endmodule

FILE: verif/packed_pixel_line_mirror_top_test.sv
// self-checking testbench for the packed pixel line mirror
module packed_pixel_line_mirror_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pplm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [2:0] FMT_BAD_6 = 3'd6;
  localparam logic [2:0] FMT_BAD_7 = 3'd7;
  localparam logic [2:0] FMT_LIST [6] = '{FMT_1BPP, FMT_4BPP, FMT_8BPP,
                                          FMT_16BPP, FMT_24BPP, FMT_32BPP};
  localparam int BPP_LIST [6] = '{1, 4, 8, 16, 24, 32};
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1650;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } mirror_out_t;

  class line_mirror_scoreboard;
    logic [7:0]  line_bytes [2*MAX_LINE_BYTES];
    bit          fill_bank;
    int unsigned fill_pos;
    int unsigned emit_pos;
    int unsigned row_bytes;
    bit          row_waiting;
    logic [2:0]  fmt;
    int unsigned width;
    mirror_out_t expected_out [$];
    int          errors;

    function new();
      fill_bank = 1'b0;
      fill_pos = 0;
      emit_pos = 0;
      row_bytes = 0;
      row_waiting = 1'b0;
      fmt = FMT_8BPP;
      width = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PIXEL_FORMAT) fmt = val[2:0];
      else if (idx == CFG_PIXEL_WIDTH) width = 32'(val);
    endfunction

    // bytes past the stored row read as zero
    function logic [7:0] stored(int unsigned bank, int unsigned idx);
      if (idx >= row_bytes || idx >= MAX_LINE_BYTES) return 8'h00;
      return line_bytes[bank*MAX_LINE_BYTES + idx];
    endfunction

    function logic [7:0] mirrored(int unsigned bank, int unsigned j);
      int unsigned x;
      int unsigned b;
      int unsigned nb;
      logic [7:0]  r;
      logic [7:0]  src;
      r = 8'h00;
      nb = 0;
      if (width == 0) return 8'h00;
      case (fmt)
        FMT_1BPP: begin
          for (b = 0; b < 8; b++) begin
            if (j*8 + b < width) begin
              x = width - 1 - (j*8 + b);
              src = stored(bank, x >> 3);
              r[7-b] = src[7 - (x % 8)];
            end
          end
          return r;
        end
        FMT_4BPP: begin
          for (b = 0; b < 2; b++) begin
            if (j*2 + b < width) begin
              x = width - 1 - (j*2 + b);
              src = stored(bank, x >> 1);
              if (b == 0) r[7:4] = x[0] ? src[3:0] : src[7:4];
              else r[3:0] = x[0] ? src[3:0] : src[7:4];
            end
          end
          return r;
        end
        FMT_8BPP:  nb = 1;
        FMT_16BPP: nb = 2;
        FMT_24BPP: nb = 3;
        FMT_32BPP: nb = 4;
        default: return 8'h00;
      endcase
      if (j >= width*nb) return 8'h00;
      return stored(bank, (width - 1 - j/nb)*nb + j%nb);
    endfunction

    // read side comes first, then the store and any bank swap
    function void take_input(logic [7:0] value, logic row_end, logic is_drain);
      mirror_out_t want;
      int unsigned rbank;
      want = '0;
      rbank = fill_bank ? 0 : 1;
      if (row_waiting && emit_pos < row_bytes) begin
        want.data = mirrored(rbank, emit_pos);
        want.valid = 1'b1;
        if (emit_pos + 1 == row_bytes) begin
          want.last = 1'b1;
          row_waiting = 1'b0;
        end
        emit_pos++;
      end
      if (!is_drain) begin
        if (fill_pos < MAX_LINE_BYTES) begin
          line_bytes[fill_bank*MAX_LINE_BYTES + fill_pos] = value;
          fill_pos++;
        end
        if (row_end) begin
          row_bytes = fill_pos;
          fill_bank = !fill_bank;
          fill_pos = 0;
          emit_pos = 0;
          row_waiting = (row_bytes != 0);
        end
      end
      expected_out.push_back(want);
    endfunction

    function void check_result(logic [7:0] data, logic valid, logic last);
      mirror_out_t want;
      if (expected_out.size() == 0) begin
        $display("%0t: result with nothing expected: out_byte %02h out_valid %0b out_last %0b",
                 $time, data, valid, last);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        errors++;
      end
      if (valid !== want.valid) begin
        $display("%0t: out_valid expected %0b actual %0b", $time, want.valid, valid);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = '0;
  logic                  end_of_row = 1'b0;
  logic                  drain = 1'b0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_valid;
  logic                  out_last;

  line_mirror_scoreboard sb;
  bit burst = 1'b0;
  bit sink_free = 1'b0;
  int hold_cycles = 0;
  int quiet = 0;
  int items_sent = 0;

  packed_pixel_line_mirror_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .end_of_row (end_of_row),
    .drain      (drain),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .out_byte   (out_byte),
    .out_valid  (out_valid),
    .out_last   (out_last)
  );

  always #5ns clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pixel_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      res_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!sink_free && $urandom_range(0, 4) == 0) begin
      res_ready <= 1'b0;
      hold_cycles <= idle_gap();
    end else begin
      res_ready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) sink_free <= !sink_free;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(out_byte, out_valid, out_last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= WATCHDOG_LIMIT) begin
      $display("** packed_pixel_line_mirror_top: FAILED **");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  task automatic send_item(input logic [7:0] value, input logic row_end, input logic is_drain);
    int gap;
    gap = burst ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    end_of_row <= row_end;
    drain <= is_drain;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_input(value, row_end, is_drain);
    items_sent++;
  endtask

  // noisy rows get stray drains and the odd early end of row
  task automatic send_row(input int unsigned data_len, input int unsigned pad, input bit noisy);
    int unsigned stride;
    int unsigned i;
    logic        row_end;
    stride = data_len + pad;
    for (i = 0; i < stride; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) send_item(8'($urandom), 1'($urandom), 1'b1);
      row_end = (i == stride - 1) || (noisy && $urandom_range(0, 99) == 0);
      send_item(i < data_len ? pixel_byte() : 8'($urandom), row_end, 1'b0);
    end
  endtask

  task automatic drain_row(input int unsigned count);
    repeat (count) send_item(8'($urandom), 1'($urandom), 1'b1);
  endtask

  // every transfer so far has its result back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(input logic [2:0] fmt, input logic [15:0] width, input bit spare);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    int                    n;
    int                    k;
    idx[0] = CFG_PIXEL_FORMAT;
    val[0] = {13'd0, fmt};
    idx[1] = CFG_PIXEL_WIDTH;
    val[1] = width;
    n = 2;
    if (spare) begin
      idx[2] = CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI));
      val[2] = 16'($urandom);
      n = 3;
    end
    for (k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          random_start;
    int          kind;
    int          pick;
    int unsigned bpp;
    int unsigned data_len;
    int unsigned pad;
    logic [2:0]  fmt;
    logic [15:0] width;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain with nothing stored
    send_item(8'h3c, 1'b1, 1'b1);
    wait_idle();
    // 1 bit pixels repacked, unused tail bits and padding zero, drain ignores end of row
    write_regs(FMT_1BPP, 16'd11, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    repeat (3) send_item(8'h5a, 1'b1, 1'b1);
    wait_idle();
    // new row arrives before the old one is out: rest of the old row abandoned
    write_regs(FMT_4BPP, 16'd3, 1'b0);
    send_item(8'h12, 1'b0, 1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    drain_row(2);
    wait_idle();
    // settings changed part way through reading out a row
    write_regs(FMT_24BPP, 16'd2, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    wait_idle();
    write_regs(FMT_16BPP, 16'd3, 1'b0);
    drain_row(2);
    wait_idle();
    write_regs(FMT_BAD_6, 16'd2, 1'b0);
    drain_row(1);
    wait_idle();
    write_regs(FMT_32BPP, 16'd0, 1'b0);
    drain_row(1);
    wait_idle();
    write_regs(FMT_8BPP, 16'd6, 1'b0);
    drain_row(2);
    wait_idle();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      pick = $urandom_range(0, 5);
      fmt = FMT_LIST[pick];
      bpp = BPP_LIST[pick];
      width = 16'($urandom_range(1, 384 / bpp));
      case (kind)
        0: fmt = $urandom_range(0, 1) ? FMT_BAD_6 : FMT_BAD_7;
        1: width = 16'd0;
        2: width = 16'hffff;
        3: width = 16'd1;
        default: ;
      endcase
      write_regs(fmt, width, $urandom_range(0, 4) == 0);
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 5)) begin
        if (kind >= 3 && $urandom_range(0, 7) != 0) data_len = (width * bpp + 7) / 8;
        else data_len = $urandom_range(1, 48);
        pad = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        send_row(data_len, pad, 1'b1);
      end
      // sometimes leave the last row stored across the next settings change
      if ($urandom_range(0, 2) != 0) drain_row(data_len + pad + $urandom_range(0, 2));
      wait_idle();
      burst = 1'b0;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_out.size() == 0)
      $display("** packed_pixel_line_mirror_top: PASSED **");
    else
      $display("** packed_pixel_line_mirror_top: FAILED **");
    $finish;
  end

endmodule
